>>> rtl/qrm_pkg.sv
// Package for the quaternion to rotation matrix block: widths, constants and
// shared types. Depends on nothing; every other file in rtl imports it.
package qrm_pkg;

  localparam int IN_W      = 16;               // Q2.14 input part
  localparam int PROD_W    = 2 * IN_W;         // Q4.28 pairwise product
  localparam int N_W       = PROD_W + 1;       // squared norm, up to 2^32
  localparam int NUM_W     = PROD_W + 2;       // signed numerator
  localparam int MAG_W     = NUM_W - 1;        // numerator magnitude
  localparam int REM_W     = N_W + 1;          // divider partial remainder
  localparam int QUO_W     = IN_W;             // quotient at twice the output scale
  localparam int DIV_STEPS = QUO_W;            // one quotient bit per stage
  localparam int LANES     = 9;                // matrix entries, row by row
  localparam int OUT_W     = 16;

  localparam logic signed [OUT_W-1:0] Q14_ONE = 16'sd16384;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  // Data that rides alongside the divider lanes.
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } side_t;

endpackage

>>> rtl/qrm_quat_if.sv
// Input channel of the quaternion to rotation matrix block: one quaternion
// per word with a valid/ready handshake. Depends on qrm_pkg.
interface qrm_quat_if import qrm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  quat_w;
  logic signed [IN_W-1:0]  quat_x;
  logic signed [IN_W-1:0]  quat_y;
  logic signed [IN_W-1:0]  quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> rtl/qrm_mat_if.sv
// Output channel of the quaternion to rotation matrix block: nine Q2.14
// entries and the zero flag per word, valid/ready handshake. Depends on qrm_pkg.
interface qrm_mat_if import qrm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] m00;
  logic signed [OUT_W-1:0] m01;
  logic signed [OUT_W-1:0] m02;
  logic signed [OUT_W-1:0] m10;
  logic signed [OUT_W-1:0] m11;
  logic signed [OUT_W-1:0] m12;
  logic signed [OUT_W-1:0] m20;
  logic signed [OUT_W-1:0] m21;
  logic signed [OUT_W-1:0] m22;
  logic                    zero_input;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_input, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_input, output ready);
endinterface

>>> rtl/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix, signed Q2.14 in and out.
// Depends on qrm_pkg, qrm_quat_if, qrm_mat_if and qrm_div.
//
// Takes one quaternion a cycle and gives its rotation matrix, one word in, one
// word out. The quaternion need not be of unit length: each entry is its exact
// numerator times 16384 divided by the squared norm, rounded to nearest with
// ties away from zero. The divider resolves one quotient bit per stage over
// sixteen stages, after three stages of products, sums and magnitudes and
// before a final rounding stage. An all-zero quaternion gives the identity
// with zero_input set. When the output word is not taken, the whole pipeline
// holds in place.
module quaternion_to_rotation_matrix_top import qrm_pkg::*; (
  input logic      clk,
  input logic      rst,
  qrm_quat_if.sink quat,
  qrm_mat_if.source mat
);

  logic en;

  // Stage 1: pairwise products.
  logic                     v1;
  logic                     zero1;
  logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, xz, xw, yz, yw, zw;

  // Stage 2: norm and signed numerators.
  logic                    v2;
  logic                    zero2;
  logic [N_W-1:0]          n2;
  logic signed [NUM_W-1:0] num2 [LANES];

  // Stage 3: magnitudes and signs.
  logic           v3;
  logic [N_W-1:0] n3;
  mag_t           mag3 [LANES];
  side_t          side3;

  logic           vd;
  quo_t           quo_d [LANES];
  side_t          side_d;

  logic signed [OUT_W-1:0] entry [LANES];
  logic signed [OUT_W-1:0] res   [LANES];
  logic                    res_zero;
  logic                    out_valid;

  assign en         = !out_valid || mat.ready;
  assign quat.ready = en;

  function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    ext = NUM_W'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1 <= (quat.quat_w == '0) && (quat.quat_x == '0) &&
               (quat.quat_y == '0) && (quat.quat_z == '0);
      ww <= quat.quat_w * quat.quat_w;
      xx <= quat.quat_x * quat.quat_x;
      yy <= quat.quat_y * quat.quat_y;
      zz <= quat.quat_z * quat.quat_z;
      xy <= quat.quat_x * quat.quat_y;
      xz <= quat.quat_x * quat.quat_z;
      xw <= quat.quat_x * quat.quat_w;
      yz <= quat.quat_y * quat.quat_z;
      yw <= quat.quat_y * quat.quat_w;
      zw <= quat.quat_z * quat.quat_w;
    end
  end

  logic signed [NUM_W-1:0] n_sum;
  assign n_sum = ext(ww) + ext(xx) + ext(yy) + ext(zz);

  always_ff @(posedge clk) begin
    if (en) begin
      zero2   <= zero1;
      n2      <= n_sum[N_W-1:0];
      num2[0] <= ext(ww) + ext(xx) - ext(yy) - ext(zz);
      num2[1] <= (ext(xy) - ext(zw)) <<< 1;
      num2[2] <= (ext(xz) + ext(yw)) <<< 1;
      num2[3] <= (ext(xy) + ext(zw)) <<< 1;
      num2[4] <= ext(ww) - ext(xx) + ext(yy) - ext(zz);
      num2[5] <= (ext(yz) - ext(xw)) <<< 1;
      num2[6] <= (ext(xz) - ext(yw)) <<< 1;
      num2[7] <= (ext(yz) + ext(xw)) <<< 1;
      num2[8] <= ext(ww) - ext(xx) - ext(yy) + ext(zz);
    end
  end

  // Every numerator is bounded by the norm, so its magnitude fits MAG_W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      n3         <= n2;
      side3.zero <= zero2;
      for (int l = 0; l < LANES; l++) begin
        side3.neg[l] <= num2[l][NUM_W-1];
        mag3[l]      <= num2[l][NUM_W-1] ? MAG_W'(-num2[l]) : MAG_W'(num2[l]);
      end
    end
  end

  qrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .n        (n3),
    .mag      (mag3),
    .side     (side3),
    .out_valid(vd),
    .quo      (quo_d),
    .out_side (side_d)
  );

  // The divider gives floor(2*16384*mag/n); halving with a carry in rounds
  // to nearest with ties away from zero once the sign is put back.
  always_comb begin
    logic [QUO_W:0]   half_sum;
    logic [QUO_W-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      half_sum = {1'b0, quo_d[l]} + (QUO_W+1)'(1);
      q        = half_sum[QUO_W:1];
      if (side_d.zero) begin
        entry[l] = (l == 0 || l == 4 || l == 8) ? Q14_ONE : '0;
      end else if (side_d.neg[l]) begin
        entry[l] = (q > QUO_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(-q);
      end else begin
        entry[l] = q[QUO_W-1] ? OUT_MAX : OUT_W'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_zero <= side_d.zero;
      for (int l = 0; l < LANES; l++) begin
        res[l] <= entry[l];
      end
    end
  end

  assign mat.valid      = out_valid;
  assign mat.m00        = res[0];
  assign mat.m01        = res[1];
  assign mat.m02        = res[2];
  assign mat.m10        = res[3];
  assign mat.m11        = res[4];
  assign mat.m12        = res[5];
  assign mat.m20        = res[6];
  assign mat.m21        = res[7];
  assign mat.m22        = res[8];
  assign mat.zero_input = res_zero;

endmodule

>>> rtl/qrm_div.sv
// Pipelined restoring divider: nine numerator magnitudes over one shared
// divisor, one quotient bit per register stage. Depends on qrm_pkg.
module qrm_div import qrm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [N_W-1:0] n,
  input  mag_t           mag [LANES],
  input  side_t          side,
  output logic           out_valid,
  output quo_t           quo [LANES],
  output side_t          out_side
);

  logic           valid_r [DIV_STEPS];
  logic [N_W-1:0] n_r     [DIV_STEPS];
  side_t          side_r  [DIV_STEPS];
  rem_t           rem_r   [DIV_STEPS][LANES];
  quo_t           quo_r   [DIV_STEPS][LANES];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic           cur_valid;
    logic [N_W-1:0] cur_n;
    side_t          cur_side;
    rem_t           trial [LANES];
    quo_t           cur_quo [LANES];
    logic [LANES-1:0] take;

    // The first step sees the magnitude itself, which never exceeds the
    // divisor; later steps shift the remainder left by one.
    if (s == 0) begin : g_first
      always_comb begin
        cur_valid = in_valid;
        cur_n     = n;
        cur_side  = side;
        for (int l = 0; l < LANES; l++) begin
          trial[l]   = REM_W'(mag[l]);
          cur_quo[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        cur_valid = valid_r[s-1];
        cur_n     = n_r[s-1];
        cur_side  = side_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          trial[l]   = {rem_r[s-1][l][REM_W-2:0], 1'b0};
          cur_quo[l] = quo_r[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        take[l] = trial[l] >= REM_W'(cur_n);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]    <= cur_n;
        side_r[s] <= cur_side;
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= take[l] ? trial[l] - REM_W'(cur_n) : trial[l];
          quo_r[s][l] <= {cur_quo[l][QUO_W-2:0], take[l]};
        end
      end
    end
  end

  always_comb begin
    out_valid = valid_r[DIV_STEPS-1];
    out_side  = side_r[DIV_STEPS-1];
    for (int l = 0; l < LANES; l++) begin
      quo[l] = quo_r[DIV_STEPS-1][l];
    end
  end

endmodule
